/* sv/clib_pkg.sv */
// console line input buffer: shared types and character constants
// no dependencies; imported by clib_ctrl, clib_out and the top level
package clib_pkg;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BELL   = 8'h07;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_EMPTY   = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    JOB_ECHO,
    JOB_ERASE,
    JOB_DELIVER,
    JOB_EMPTY
  } job_kind_t;

  typedef enum logic [1:0] {
    ERASE_BS0,
    ERASE_SPACE,
    ERASE_BS1,
    ERASE_BELL
  } erase_step_t;

  typedef struct packed {
    logic      valid;
    job_kind_t kind;
    logic [7:0] data;
    logic      line_ready;
  } job_req_t;

endpackage

/* sv/clib_ring.sv */
// console line input buffer: byte ring storage
// single write port, single read port with registered read data; no package use
module clib_ring #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] ring_mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/clib_ctrl.sv */
// console line input buffer: request decode, ring pointers, mode register
// uses clib_pkg; drives clib_ring ports and hands jobs to clib_out
module clib_ctrl #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                accept,
  input  logic                req_op,
  input  logic [7:0]          req_byte,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output clib_pkg::job_req_t  job
);
  import clib_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic          cr_drop_r;
  logic [AW-1:0] head_idx_r, head_idx_nxt;
  logic          head_wrap_r, head_wrap_nxt;
  logic [AW-1:0] tail_idx_r, tail_idx_nxt;
  logic          tail_wrap_r, tail_wrap_nxt;

  logic       ring_empty;
  logic       ring_full;
  logic [7:0] eff_byte;
  logic       is_erase;
  logic       is_swallow;

  assign ring_empty = (head_idx_r == tail_idx_r) && (head_wrap_r == tail_wrap_r);
  assign ring_full  = (head_idx_r == tail_idx_r) && (head_wrap_r != tail_wrap_r);
  assign is_erase   = (req_byte == CH_BS) || (req_byte == CH_DEL);
  assign is_swallow = (req_byte == CH_CTRL_P) || (req_byte == CH_TILDE) ||
                      ((req_byte == CH_CR) && cr_drop_r);
  assign eff_byte   = (req_byte == CH_CR) ? CH_LF : req_byte;

  always_comb begin
    head_idx_nxt   = head_idx_r;
    head_wrap_nxt  = head_wrap_r;
    tail_idx_nxt   = tail_idx_r;
    tail_wrap_nxt  = tail_wrap_r;
    wr_en          = 1'b0;
    wr_addr        = head_idx_r;
    wr_data        = eff_byte;
    rd_en          = 1'b0;
    rd_addr        = tail_idx_r;
    job.valid      = 1'b0;
    job.kind       = JOB_ECHO;
    job.data       = eff_byte;
    job.line_ready = (eff_byte == CH_LF);
    if (accept) begin
      if (req_op) begin
        job.valid = 1'b1;
        if (ring_empty) begin
          job.kind = JOB_EMPTY;
        end else begin
          job.kind = JOB_DELIVER;
          rd_en    = 1'b1;
          if (tail_idx_r == LAST_IDX) begin
            tail_idx_nxt  = '0;
            tail_wrap_nxt = ~tail_wrap_r;
          end else begin
            tail_idx_nxt = tail_idx_r + AW'(1);
          end
        end
      end else if (is_erase) begin
        if (!ring_empty) begin
          job.valid = 1'b1;
          job.kind  = JOB_ERASE;
          if (head_idx_r == '0) begin
            head_idx_nxt  = LAST_IDX;
            head_wrap_nxt = ~head_wrap_r;
          end else begin
            head_idx_nxt = head_idx_r - AW'(1);
          end
        end
      end else if (!is_swallow && !ring_full) begin
        job.valid = 1'b1;
        job.kind  = JOB_ECHO;
        wr_en     = 1'b1;
        if (head_idx_r == LAST_IDX) begin
          head_idx_nxt  = '0;
          head_wrap_nxt = ~head_wrap_r;
        end else begin
          head_idx_nxt = head_idx_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_drop_r   <= 1'b0;
      head_idx_r  <= '0;
      head_wrap_r <= 1'b0;
      tail_idx_r  <= '0;
      tail_wrap_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cr_drop_r <= cfg_wr_data;
      end
      head_idx_r  <= head_idx_nxt;
      head_wrap_r <= head_wrap_nxt;
      tail_idx_r  <= tail_idx_nxt;
      tail_wrap_r <= tail_wrap_nxt;
    end
  end

endmodule

/* sv/clib_out.sv */
// console line input buffer: result sequencer and output register
// uses clib_pkg; takes jobs from clib_ctrl and read data from clib_ring
module clib_out (
  input  logic                clk,
  input  logic                rst_n,
  input  clib_pkg::job_req_t  job,
  input  logic [7:0]          rd_data,
  output logic                free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import clib_pkg::*;

  logic        busy_r;
  job_kind_t   kind_r;
  logic [7:0]  byte_r;
  logic        lr_r;
  erase_step_t step_r;

  logic        fire;
  logic [7:0]  res_byte;
  logic        res_lr;
  out_kind_t   res_kind;
  logic        res_last;

  always_comb begin
    res_kind = KIND_ECHO;
    res_byte = byte_r;
    res_lr   = 1'b0;
    res_last = 1'b1;
    unique case (kind_r)
      JOB_ECHO: begin
        res_lr = lr_r;
      end
      JOB_ERASE: begin
        res_last = (step_r == ERASE_BELL);
        unique case (step_r)
          ERASE_BS0:   res_byte = CH_BS;
          ERASE_SPACE: res_byte = CH_SPACE;
          ERASE_BS1:   res_byte = CH_BS;
          ERASE_BELL:  res_byte = CH_BELL;
          default:     res_byte = CH_BS;
        endcase
      end
      JOB_DELIVER: begin
        res_kind = KIND_DELIVER;
        res_byte = rd_data;
      end
      JOB_EMPTY: begin
        res_kind = KIND_EMPTY;
        res_byte = '0;
      end
      default: res_byte = byte_r;
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {7'd0, res_lr, res_byte};
  assign out_tuser  = res_kind;
  assign out_tlast  = res_last;
  assign fire       = busy_r && out_tready;
  assign free       = !busy_r || (fire && res_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ERASE_BS0;
      kind_r <= JOB_ECHO;
    end else if (job.valid) begin
      busy_r <= 1'b1;
      kind_r <= job.kind;
      step_r <= ERASE_BS0;
    end else if (fire && res_last) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      step_r <= erase_step_t'(step_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid) begin
      byte_r <= job.data;
      lr_r   <= job.line_ready;
    end
  end

endmodule

/* sv/console_line_input_buffer_top.sv */
// console line input buffer: top level
// uses clib_pkg, clib_ring, clib_ctrl, clib_out
//
// Input channel in_*: one request per transfer, either a received terminal
// byte or a reader request for one buffered byte. Result channel out_*:
// echo bytes, delivered bytes and empty reports; out_tlast closes the
// results of one request. A plain byte gives one echo, a backspace or
// delete on a non-empty ring gives four echoes, a reader request gives one
// delivered byte or one empty report; swallowed, dropped and overflowing
// bytes give nothing.
// The first result is registered and shows in the cycle after the request
// is taken. The result sequencer drains one result per cycle while the
// receiver is ready; the next request is taken in the cycle the last
// result of the previous one leaves.
// The ring sits in one memory with a registered read; pointers and the mode
// register live in flip-flops. Reset empties the ring at once and clears
// the carriage return mode to newline mapping; no clearing pass is needed.
// A stalled receiver holds the current result and blocks new requests.
module console_line_input_buffer_top #(
  parameter int BUF_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,   // cr_drop_mode
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [clib_pkg::IN_TDATA_W-1:0] in_tdata,      // operation, rx_byte, zero fill
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [clib_pkg::OUT_TDATA_W-1:0] out_tdata,    // out_byte, line_ready, zero fill
  output logic [1:0]                      out_tuser,     // out_kind
  output logic                            out_tlast
);
  import clib_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic          accept;
  logic          free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  job_req_t      job;

  assign in_tready = free;
  assign accept    = in_tvalid && free;

  clib_ctrl #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .req_op      (in_tdata[0]),
    .req_byte    (in_tdata[8:1]),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .job         (job)
  );

  clib_ring #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  clib_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .rd_data    (rd_data),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// testbench for console_line_input_buffer_top: directed table then random requests,
// results checked against an in-bench line buffer predictor; uses clib_pkg and the rtl
module tb_top;
  import clib_pkg::*;

  localparam int BUF_DEPTH = 128;
  localparam int PTR_MOD = 2 * BUF_DEPTH;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int MIXED_ITEMS = 20;
  localparam int FILL_ITEMS = 136;
  localparam int DRAIN_ITEMS = 80;
  localparam int NUM_DIRECTED = 22;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic MODE_CR_TO_LF = 1'b0;
  localparam logic MODE_CR_DROP  = 1'b1;

  typedef struct packed {
    out_kind_t  kind;
    logic [7:0] ch;
    logic       line_ready;
    logic       fin;
  } console_result_t;

  typedef struct packed {
    logic       mode;
    logic       op;
    logic [7:0] ch;
    logic       typed;
    out_kind_t  kind;
    logic [7:0] ch_exp;
    logic       ready;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;      // operation, rx_byte, zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // out_byte, line_ready, zero fill
  logic [1:0]  out_tuser;          // out_kind
  logic        out_tlast;

  // line buffer model state
  logic [7:0]  line_ring [BUF_DEPTH];
  int unsigned head_count = 0;
  int unsigned tail_count = 0;
  logic        cr_drop = MODE_CR_TO_LF;

  console_result_t console_out_due[$];
  int  errors = 0;
  int  stall_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  squeeze_request = 1'b0;
  bit  squeeze_done = 1'b0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{MODE_CR_TO_LF, OP_READ, 8'hff,     1'b1, KIND_EMPTY,   8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   CH_BS,     1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   CH_DEL,    1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   8'h00,     1'b1, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   8'hff,     1'b1, KIND_ECHO,    8'hff,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   CH_CTRL_P, 1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   CH_TILDE,  1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   CH_CR,     1'b1, KIND_ECHO,    CH_LF,  1'b1},
    '{MODE_CR_TO_LF, OP_RX,   CH_LF,     1'b1, KIND_ECHO,    CH_LF,  1'b1},
    '{MODE_CR_TO_LF, OP_RX,   CH_BS,     1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   8'h41,     1'b1, KIND_ECHO,    8'h41,  1'b0},
    '{MODE_CR_TO_LF, OP_RX,   CH_DEL,    1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_READ, 8'hff,     1'b1, KIND_DELIVER, 8'h00,  1'b0},
    '{MODE_CR_TO_LF, OP_READ, 8'h00,     1'b1, KIND_DELIVER, 8'hff,  1'b0},
    '{MODE_CR_TO_LF, OP_READ, 8'h55,     1'b1, KIND_DELIVER, CH_LF,  1'b0},
    '{MODE_CR_TO_LF, OP_READ, 8'haa,     1'b1, KIND_EMPTY,   8'h00,  1'b0},
    '{MODE_CR_DROP,  OP_RX,   CH_CR,     1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_DROP,  OP_RX,   CH_LF,     1'b1, KIND_ECHO,    CH_LF,  1'b1},
    '{MODE_CR_DROP,  OP_RX,   CH_CTRL_P, 1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_DROP,  OP_RX,   CH_CR,     1'b0, KIND_ECHO,    8'h00,  1'b0},
    '{MODE_CR_DROP,  OP_READ, 8'hff,     1'b1, KIND_DELIVER, CH_LF,  1'b0},
    '{MODE_CR_DROP,  OP_READ, 8'h00,     1'b1, KIND_EMPTY,   8'h00,  1'b0}
  };

  console_line_input_buffer_top #(
    .BUF_DEPTH(BUF_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void push_result(out_kind_t kind, logic [7:0] ch, logic ready, logic fin);
    console_result_t r;
    r.kind = kind;
    r.ch = ch;
    r.line_ready = ready;
    r.fin = fin;
    console_out_due.push_back(r);
  endfunction

  // line discipline: echo, erase, swallow, store and read back
  function automatic void edit_line(logic op, logic [7:0] c_in);
    int unsigned fill;
    logic [7:0]  c;
    logic        swallow;
    fill = (head_count + PTR_MOD - tail_count) % PTR_MOD;
    c = c_in;
    swallow = (c == CH_CTRL_P) || (c == CH_TILDE) || (c == CH_CR && cr_drop);
    if (op == OP_READ) begin
      if (fill == 0) begin
        push_result(KIND_EMPTY, 8'h00, 1'b0, 1'b1);
      end else begin
        push_result(KIND_DELIVER, line_ring[tail_count % BUF_DEPTH], 1'b0, 1'b1);
        tail_count = (tail_count + 1) % PTR_MOD;
      end
    end else if (c == CH_BS || c == CH_DEL) begin
      if (fill != 0) begin
        head_count = (head_count + PTR_MOD - 1) % PTR_MOD;
        push_result(KIND_ECHO, CH_BS, 1'b0, 1'b0);
        push_result(KIND_ECHO, CH_SPACE, 1'b0, 1'b0);
        push_result(KIND_ECHO, CH_BS, 1'b0, 1'b0);
        push_result(KIND_ECHO, CH_BELL, 1'b0, 1'b1);
      end
    end else if (!swallow && fill < BUF_DEPTH) begin
      if (c == CH_CR) begin
        c = CH_LF;
      end
      line_ring[head_count % BUF_DEPTH] = c;
      head_count = (head_count + 1) % PTR_MOD;
      push_result(KIND_ECHO, c, c == CH_LF, 1'b1);
    end
  endfunction

  task automatic send_request(input logic op, input logic [7:0] ch, input logic typed,
                              input console_result_t typed_res);
    int gap;
    int n;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if ($urandom_range(0, 15) == 0) begin
      tx_idle_on = !tx_idle_on;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, ch, op};
    do @(posedge clk); while (!in_tready);
    n = console_out_due.size();
    edit_line(op, ch);
    if (typed) begin
      while (console_out_due.size() > n) begin
        void'(console_out_due.pop_back());
      end
      console_out_due.push_back(typed_res);
    end
  endtask

  task automatic send_plain(input logic op, input logic [7:0] ch);
    send_request(op, ch, 1'b0, console_result_t'(0));
  endtask

  // typing with line edits, carriage returns and reads mixed in
  task automatic send_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_plain(OP_RX, 8'($urandom_range(0, 255)));
    end else if (r < 62) begin
      send_plain(OP_READ, 8'($urandom_range(0, 255)));
    end else if (r < 72) begin
      send_plain(OP_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL);
    end else if (r < 80) begin
      send_plain(OP_RX, CH_CR);
    end else if (r < 86) begin
      send_plain(OP_RX, CH_LF);
    end else if (r < 90) begin
      send_plain(OP_RX, CH_CTRL_P);
    end else if (r < 94) begin
      send_plain(OP_RX, CH_TILDE);
    end else begin
      send_plain(OP_RX, 8'($urandom_range(32, 126)));
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (console_out_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cr_drop = mode;
  endtask

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result();
    console_result_t want;
    if (console_out_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d byte %02h ready %0b last %0b",
               $time, out_tuser, out_tdata[7:0], out_tdata[8], out_tlast);
      errors++;
    end else begin
      want = console_out_due.pop_front();
      compare_field("out_kind", 8'(want.kind), 8'(out_tuser));
      compare_field("out_byte", want.ch, out_tdata[7:0]);
      compare_field("line_ready", 8'(want.line_ready), 8'(out_tdata[8]));
      compare_field("last", 8'(want.fin), 8'(out_tlast));
    end
  endfunction

  // result side
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if ($urandom_range(0, 15) == 0) begin
        rx_idle_on = !rx_idle_on;
      end
      if (squeeze_request && !squeeze_done) begin
        gap = HOLD_CYCLES;
        squeeze_done = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result();
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL console_line_input_buffer_top");
        $finish;
      end
    end
  end

  // request side
  initial begin
    directed_row_t   row;
    console_result_t typed_res;
    logic [7:0]      ch;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(MODE_CR_TO_LF);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.mode != cr_drop) begin
        settle();
        write_mode(row.mode);
      end
      typed_res.kind = row.kind;
      typed_res.ch = row.ch_exp;
      typed_res.line_ready = row.ready;
      typed_res.fin = 1'b1;
      send_request(row.op, row.ch, row.typed, typed_res);
    end

    for (int i = 0; i < MIXED_ITEMS; i++) begin
      send_mixed();
    end

    // fill past full with the result side held off, erase, refill, drain
    settle();
    write_mode(MODE_CR_TO_LF);
    squeeze_request = 1'b1;
    for (int i = 0; i < FILL_ITEMS; i++) begin
      do ch = 8'($urandom_range(0, 255)); while (ch == CH_BS || ch == CH_DEL);
      send_plain(OP_RX, ch);
    end
    repeat (3) send_plain(OP_RX, CH_DEL);
    repeat (4) send_plain(OP_RX, 8'($urandom_range(0, 255)) | 8'h80);
    for (int i = 0; i < DRAIN_ITEMS; i++) begin
      send_plain(OP_READ, 8'($urandom_range(0, 255)));
    end

    settle();
    write_mode(MODE_CR_DROP);
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      send_mixed();
    end

    settle();
    if (errors == 0) begin
      $display("PASS console_line_input_buffer_top");
    end else begin
      $display("FAIL console_line_input_buffer_top");
    end
    $finish;
  end

endmodule

/* console_line_input_buffer_top.f */
sv/clib_pkg.sv
sv/clib_ring.sv
sv/clib_ctrl.sv
sv/clib_out.sv
sv/console_line_input_buffer_top.sv
tb/tb_top.sv
